// ----- rtl/brr_pkg.sv -----
`default_nettype none
package brr_pkg;

  localparam int BRR_BUF_BYTES = 4096;
  localparam int BRR_MAX_BITS  = 32;
  localparam int BYTE_BITS     = 8;

  localparam logic [2:0] ACT_PUT       = 3'd0;
  localparam logic [2:0] ACT_GET       = 3'd1;
  localparam logic [2:0] ACT_REW_BITS  = 3'd2;
  localparam logic [2:0] ACT_REW_BYTES = 3'd3;
  localparam logic [2:0] ACT_REPORT    = 3'd4;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_PAST = 2'd1;
  localparam logic [1:0] ERR_OVER = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic [11:0] amount;
  } in_word_t;

  typedef struct packed {
    logic [31:0] bits_value;
    logic [31:0] total_bits;
    logic [1:0]  error;
  } out_word_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic check;
    logic mem_wr;
    logic mem_rd;
    logic merge;
    logic out_load;
  } brr_cmd_t;

  typedef struct packed {
    logic is_put;
    logic is_get;
    logic too_long;
    logic need_zero;
    logic read_past;
    logic addr_valid;
  } brr_sts_t;

endpackage
`default_nettype wire

// ----- rtl/brr_modaddr.sv -----
`default_nettype none
module brr_modaddr import brr_pkg::*; #(
  parameter int BUF_BYTES = BRR_BUF_BYTES,
  localparam int AW = $clog2(BUF_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire logic [31:0]   src,
  output logic      [AW-1:0] addr,
  output logic               valid
);

  if ((BUF_BYTES & (BUF_BYTES - 1)) == 0) begin : g_pow2
    logic [AW-1:0] base_r;
    logic          valid_r;

    always_ff @(posedge clk) begin
      if (load) begin
        base_r <= src[AW-1:0];
      end
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (load) begin
        valid_r <= 1'b1;
      end
    end

    assign addr  = base_r;
    assign valid = valid_r;
  end else begin : g_recip
    // The quotient estimate from the truncated reciprocal is low by at most one,
    // so a single compare and subtract finishes the remainder.
    localparam logic [63:0] RECIP_W = (64'd1 << 32) / 64'(BUF_BYTES);
    localparam logic [31:0] RECIP   = RECIP_W[31:0];
    localparam logic [31:0] BUF_C   = 32'(BUF_BYTES);
    logic [31:0]   src_r;
    logic [63:0]   prod_r;
    logic [31:0]   rem0_r;
    logic [AW-1:0] rem_r;
    logic [1:0]    cnt_r;
    logic [31:0]   rem_fix;

    assign rem_fix = (rem0_r >= BUF_C) ? (rem0_r - BUF_C) : rem0_r;

    always_ff @(posedge clk) begin
      if (load) begin
        src_r  <= src;
        prod_r <= 64'(src) * 64'(RECIP);
      end
      rem0_r <= src_r - prod_r[63:32] * BUF_C;
      rem_r  <= rem_fix[AW-1:0];
      if (!rst_n) begin
        cnt_r <= '0;
      end else if (load) begin
        cnt_r <= '0;
      end else if (cnt_r != 2'd2) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end

    assign addr  = rem_r;
    assign valid = (cnt_r == 2'd2);
  end

endmodule
`default_nettype wire

// ----- rtl/brr_dp.sv -----
`default_nettype none
module brr_dp import brr_pkg::*; #(
  parameter int BUF_BYTES = BRR_BUF_BYTES,
  parameter int MAX_BITS  = BRR_MAX_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  in_word,
  input  wire brr_cmd_t  cmd,
  output brr_sts_t       sts,
  output out_word_t      out_word
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int NW = $clog2(MAX_BITS + 1);

  logic [7:0]    mem [BUF_BYTES];

  logic [2:0]    act_r;
  logic [7:0]    byte_r;
  logic [11:0]   amt_r;
  logic [31:0]   wr_cnt_r;
  logic [31:0]   rd_idx_r;
  logic [3:0]    left_r;
  logic [31:0]   total_r;
  logic [31:0]   idx_w_r;
  logic [3:0]    left_w_r;
  logic [NW-1:0] need_r;
  logic [31:0]   val_r;
  logic [1:0]    err_r;
  logic [7:0]    rdata_r;
  out_word_t     out_word_r;

  logic [31:0]   idx2;
  logic [3:0]    left2;
  logic [12:0]   rew_t;
  logic [3:0]    take;
  logic [7:0]    piece;
  logic [NW-1:0] sh;
  logic          addr_load;
  logic [31:0]   addr_src;
  logic [AW-1:0] addr;
  logic          addr_valid;

  assign idx2  = (left_w_r == 4'd0) ? (idx_w_r + 32'd1) : idx_w_r;
  assign left2 = (left_w_r == 4'd0) ? 4'(BYTE_BITS) : left_w_r;
  assign rew_t = {9'd0, left_r} + {1'b0, amt_r};

  assign take  = (need_r < NW'(left_w_r)) ? 4'(need_r) : left_w_r;
  assign piece = (rdata_r & (8'hFF >> (4'(BYTE_BITS) - left_w_r))) >> (left_w_r - take);
  assign sh    = need_r - NW'(take);

  assign sts.is_put     = (act_r == ACT_PUT);
  assign sts.is_get     = (act_r == ACT_GET);
  assign sts.too_long   = (amt_r > 12'(MAX_BITS));
  assign sts.need_zero  = (need_r == '0);
  assign sts.read_past  = (idx2 >= wr_cnt_r);
  assign sts.addr_valid = addr_valid;

  assign addr_load = (cmd.exec && sts.is_put)
                  || (cmd.check && !sts.need_zero && !sts.read_past);
  assign addr_src  = cmd.exec ? wr_cnt_r : idx2;

  brr_modaddr #(
    .BUF_BYTES(BUF_BYTES)
  ) u_modaddr (
    .clk  (clk),
    .rst_n(rst_n),
    .load (addr_load),
    .src  (addr_src),
    .addr (addr),
    .valid(addr_valid)
  );

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= byte_r;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_cnt_r <= '0;
      rd_idx_r <= '0;
      left_r   <= 4'(BYTE_BITS);
      total_r  <= '0;
    end else begin
      if (cmd.exec) begin
        case (act_r)
          ACT_REW_BITS: begin
            total_r  <= total_r - {20'd0, amt_r};
            rd_idx_r <= rd_idx_r - {22'd0, rew_t[12:3]};
            left_r   <= {1'b0, rew_t[2:0]};
          end
          ACT_REW_BYTES: begin
            total_r  <= total_r - {17'd0, amt_r, 3'd0};
            rd_idx_r <= rd_idx_r - {20'd0, amt_r};
          end
          default: begin
          end
        endcase
      end
      if (cmd.check && sts.need_zero) begin
        rd_idx_r <= idx_w_r;
        left_r   <= left_w_r;
        total_r  <= total_r + {20'd0, amt_r};
      end
      if (cmd.mem_wr) begin
        wr_cnt_r <= wr_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= in_word.action;
      byte_r <= in_word.data_byte;
      amt_r  <= in_word.amount;
    end
    if (cmd.exec) begin
      idx_w_r  <= rd_idx_r;
      left_w_r <= left_r;
      need_r   <= amt_r[NW-1:0];
      val_r    <= '0;
      err_r    <= (sts.is_get && sts.too_long) ? ERR_OVER : ERR_OK;
    end
    if (cmd.check && !sts.need_zero) begin
      if (sts.read_past) begin
        err_r <= ERR_PAST;
        val_r <= '0;
      end else begin
        idx_w_r  <= idx2;
        left_w_r <= left2;
      end
    end
    if (cmd.merge) begin
      val_r    <= val_r | ({24'd0, piece} << sh);
      left_w_r <= left_w_r - take;
      need_r   <= need_r - NW'(take);
    end
    if (cmd.out_load) begin
      out_word_r.bits_value <= val_r;
      out_word_r.total_bits <= total_r;
      out_word_r.error      <= err_r;
    end
  end

  assign out_word = out_word_r;

endmodule
`default_nettype wire

// ----- rtl/brr_ctrl.sv -----
`default_nettype none
module brr_ctrl import brr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire brr_sts_t sts,
  output brr_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_put) begin
          state_nxt = S_ADDR;
        end else if (sts.is_get && !sts.too_long) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.need_zero || sts.read_past) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        if (sts.addr_valid) begin
          if (sts.is_put) begin
            cmd.mem_wr = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            cmd.mem_rd = 1'b1;
            state_nxt  = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.merge = 1'b1;
        state_nxt = S_CHECK;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- rtl/bit_reservoir_reader.sv -----
`default_nettype none
// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall   in_word (action, data_byte, amount)
// out_      output     out_valid / out_stall out_word (bits_value, total_bits, error)
//
// Each word is taken alone: in_stall is low only while the block is idle.
// A put executes, waits for its address and writes one byte; rewind, report and an
// over-length get go straight to the result; a get loops through check, address
// and fetch with a merge for each stored byte it touches, one byte per fetch over
// the registered memory read port. With a buffer size that is not a power of two,
// each memory access also waits for the reciprocal address remainder.
// Reset clears the counters and control state; the byte store is not cleared.
// A result waits in the output register while out_stall is high.
module bit_reservoir_reader import brr_pkg::*; #(
  parameter int BUF_BYTES = BRR_BUF_BYTES,
  parameter int MAX_BITS  = BRR_MAX_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  brr_cmd_t cmd;
  brr_sts_t sts;

  brr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  brr_dp #(
    .BUF_BYTES(BUF_BYTES),
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .cmd     (cmd),
    .sts     (sts),
    .out_word(out_word)
  );

  a_mem_addr_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_wr || cmd.mem_rd) |-> sts.addr_valid)
    else $error("memory accessed before its address was ready");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while held");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.exec)
    else $error("accepted word not executed");

  a_merge_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge |=> cmd.check)
    else $error("byte merge not followed by a check");

endmodule
`default_nettype wire
